// File: src/sql_response_packet_parser_top_defines.svh
// ----------------------------------------------------------------------------
// sql_response_packet_parser_top_defines
// Assertion macros used by the checker file of the response parser.
// ----------------------------------------------------------------------------
`ifndef SQL_RESPONSE_PACKET_PARSER_TOP_DEFINES_SVH
`define SQL_RESPONSE_PACKET_PARSER_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define SQLRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define SQLRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// what must hold on the cycle after a reset cycle
`define SQLRP_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// File: src/sqlrp_pkg.sv
// ----------------------------------------------------------------------------
// sqlrp_pkg
// Constants and the result record of the response packet parser.
// ----------------------------------------------------------------------------
package sqlrp_pkg;

  // capability bits that select the packet layouts
  localparam logic [31:0] CAP_P41     = 32'h0000_0200;
  localparam logic [31:0] CAP_TRANS   = 32'h0000_2000;
  localparam logic [31:0] CAP_SESSION = 32'h0080_0000;

  // header bytes
  localparam logic [7:0] HDR_OK  = 8'h00;
  localparam logic [7:0] HDR_ERR = 8'hff;
  localparam logic [7:0] HDR_EOF = 8'hfe;

  // length-encoded integer prefixes
  localparam logic [7:0] PFX_NULL  = 8'hfb;
  localparam logic [7:0] PFX_TWO   = 8'hfc;
  localparam logic [7:0] PFX_THREE = 8'hfd;
  localparam logic [7:0] PFX_EIGHT = 8'hfe;

  localparam logic [23:0] MAX24       = 24'hff_ffff;
  localparam logic [23:0] EOF_LIMIT   = 24'd9;
  localparam logic [23:0] EOF_MIN_P41 = 24'd5;

  localparam logic [1:0] KIND_OK    = 2'd0;
  localparam logic [1:0] KIND_ERR   = 2'd1;
  localparam logic [1:0] KIND_EOF   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  typedef struct packed {
    logic [1:0]  packet_kind;
    logic [63:0] row_count;
    logic [63:0] new_row_id;
    logic [15:0] server_status;
    logic [15:0] warning_count;
    logic [15:0] err_number;
    logic [39:0] state_text;
    logic [23:0] info_length;
    logic        malformed;
  } result_t;

endpackage

// File: src/sqlrp_byte_if.sv
// ----------------------------------------------------------------------------
// sqlrp_byte_if
// Payload byte channel: one packet byte per transfer with a last flag.
// ----------------------------------------------------------------------------
interface sqlrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

// File: src/sqlrp_result_if.sv
// ----------------------------------------------------------------------------
// sqlrp_result_if
// Result channel: one decoded summary per packet.
// ----------------------------------------------------------------------------
interface sqlrp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  packet_kind;
  logic [63:0] row_count;
  logic [63:0] new_row_id;
  logic [15:0] server_status;
  logic [15:0] warning_count;
  logic [15:0] err_number;
  logic [39:0] state_text;
  logic [23:0] info_length;
  logic        malformed;

  modport source (
    output valid, output packet_kind, output row_count, output new_row_id,
    output server_status, output warning_count, output err_number, output state_text,
    output info_length, output malformed, input ready
  );
  modport sink (
    input valid, input packet_kind, input row_count, input new_row_id,
    input server_status, input warning_count, input err_number, input state_text,
    input info_length, input malformed, output ready
  );
endinterface

// File: src/sqlrp_parser.sv
// ----------------------------------------------------------------------------
// sqlrp_parser
// Byte-wise parse state, capability register and result generation.
// ----------------------------------------------------------------------------
module sqlrp_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [31:0]              cfg_wdata,
  input  logic                     accept,
  input  logic [7:0]               payload_byte,
  input  logic                     last_byte,
  output logic                     res_valid,
  output sqlrp_pkg::result_t       res_data
);

  typedef enum logic [13:0] {
    PH_HDR        = 14'h0001,
    PH_ROWS_PFX   = 14'h0002,
    PH_ROWS_VAL   = 14'h0004,
    PH_ID_PFX     = 14'h0008,
    PH_ID_VAL     = 14'h0010,
    PH_INFO_PFX   = 14'h0020,
    PH_INFO_VAL   = 14'h0040,
    PH_STATUS     = 14'h0080,
    PH_WARN       = 14'h0100,
    PH_INFO_COUNT = 14'h0200,
    PH_ERR_CODE   = 14'h0400,
    PH_ERR_STATE  = 14'h0800,
    PH_FE         = 14'h1000,
    PH_SKIP       = 14'h2000
  } phase_t;

  typedef enum logic [1:0] {
    FLD_ROWS = 2'd0,
    FLD_ID   = 2'd1,
    FLD_INFO = 2'd2
  } lz_field_t;

  logic [31:0] caps;

  logic [23:0] byte_index, byte_index_next;
  logic [7:0]  header_value, header_value_next;
  phase_t      phase, phase_next;
  logic [3:0]  left, left_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  acc_cnt, acc_cnt_next;
  logic [63:0] rows, rows_next;
  logic [63:0] insert_id, insert_id_next;
  logic [31:0] early_bytes, early_bytes_next;
  logic [15:0] status_r, status_r_next;
  logic [15:0] warnings_r, warnings_r_next;
  logic [15:0] err_code, err_code_next;
  logic [39:0] state_chars, state_chars_next;
  logic [23:0] info_len, info_len_next;
  logic        bad_flag, bad_flag_next;

  logic        cap_p41, cap_trans, cap_session;
  phase_t      info_phase, val_phase;
  lz_field_t   lz_fld;
  logic        lz_done;
  logic [63:0] lz_val;
  logic [3:0]  left_dec;
  logic        take_done;
  logic [63:0] acc_take;
  logic [39:0] state_take;
  logic [1:0]  fe_lane;
  logic        bad_res;
  logic        eof_short;

  always_comb begin
    cap_p41     = |(caps & sqlrp_pkg::CAP_P41);
    cap_trans   = |(caps & sqlrp_pkg::CAP_TRANS);
    cap_session = |(caps & sqlrp_pkg::CAP_SESSION);
    info_phase  = cap_session ? PH_INFO_PFX : PH_INFO_COUNT;

    left_dec   = (left != 4'd0) ? left - 4'd1 : 4'd0;
    take_done  = (left_dec == 4'd0);
    acc_take   = acc | ({56'd0, payload_byte} << {acc_cnt[2:0], 3'b000});
    state_take = state_chars | ({32'd0, payload_byte} << {acc_cnt[2:0], 3'b000});
    fe_lane    = byte_index[1:0] - 2'd1;

    // which length-encoded field the current phase belongs to
    if (phase == PH_ROWS_PFX || phase == PH_ROWS_VAL) begin
      lz_fld    = FLD_ROWS;
      val_phase = PH_ROWS_VAL;
    end else if (phase == PH_ID_PFX || phase == PH_ID_VAL) begin
      lz_fld    = FLD_ID;
      val_phase = PH_ID_VAL;
    end else begin
      lz_fld    = FLD_INFO;
      val_phase = PH_INFO_VAL;
    end

    byte_index_next   = (byte_index < sqlrp_pkg::MAX24) ? byte_index + 24'd1 : byte_index;
    header_value_next = header_value;
    phase_next        = phase;
    left_next         = left;
    acc_next          = acc;
    acc_cnt_next      = acc_cnt;
    rows_next         = rows;
    insert_id_next    = insert_id;
    early_bytes_next  = early_bytes;
    status_r_next     = status_r;
    warnings_r_next   = warnings_r;
    err_code_next     = err_code;
    state_chars_next  = state_chars;
    info_len_next     = info_len;
    bad_flag_next     = bad_flag;
    lz_done           = 1'b0;
    lz_val            = acc_take;

    unique case (phase) inside
      PH_HDR: begin
        header_value_next = payload_byte;
        if (payload_byte == sqlrp_pkg::HDR_OK) begin
          phase_next = PH_ROWS_PFX;
        end else if (payload_byte == sqlrp_pkg::HDR_ERR) begin
          phase_next   = PH_ERR_CODE;
          left_next    = 4'd2;
          acc_next     = '0;
          acc_cnt_next = '0;
        end else if (payload_byte == sqlrp_pkg::HDR_EOF) begin
          phase_next = PH_FE;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_ROWS_PFX, PH_ID_PFX, PH_INFO_PFX: begin
        if (payload_byte < sqlrp_pkg::PFX_NULL) begin
          lz_done = 1'b1;
          lz_val  = {56'd0, payload_byte};
        end else begin
          acc_next     = '0;
          acc_cnt_next = '0;
          phase_next   = val_phase;
          case (payload_byte)
            sqlrp_pkg::PFX_TWO:   left_next = 4'd2;
            sqlrp_pkg::PFX_THREE: left_next = 4'd3;
            sqlrp_pkg::PFX_EIGHT: left_next = 4'd8;
            default: begin
              // null marker or error byte where a length belongs
              bad_flag_next = 1'b1;
              phase_next    = PH_SKIP;
              acc_next      = acc;
              acc_cnt_next  = acc_cnt;
            end
          endcase
        end
      end
      PH_ROWS_VAL, PH_ID_VAL, PH_INFO_VAL: begin
        left_next    = left_dec;
        acc_next     = acc_take;
        acc_cnt_next = acc_cnt + 4'd1;
        lz_done      = take_done;
      end
      PH_STATUS: begin
        left_next    = left_dec;
        acc_next     = acc_take;
        acc_cnt_next = acc_cnt + 4'd1;
        if (take_done) begin
          status_r_next = acc_take[15:0];
          if (cap_p41) begin
            phase_next   = PH_WARN;
            left_next    = 4'd2;
            acc_next     = '0;
            acc_cnt_next = '0;
          end else begin
            info_len_next = '0;
            phase_next    = info_phase;
          end
        end
      end
      PH_WARN: begin
        left_next    = left_dec;
        acc_next     = acc_take;
        acc_cnt_next = acc_cnt + 4'd1;
        if (take_done) begin
          warnings_r_next = acc_take[15:0];
          info_len_next   = '0;
          phase_next      = info_phase;
        end
      end
      PH_INFO_COUNT: begin
        if (info_len < sqlrp_pkg::MAX24) begin
          info_len_next = info_len + 24'd1;
        end
      end
      PH_ERR_CODE: begin
        left_next    = left_dec;
        acc_next     = acc_take;
        acc_cnt_next = acc_cnt + 4'd1;
        if (take_done) begin
          err_code_next = acc_take[15:0];
          if (cap_p41) begin
            phase_next   = PH_ERR_STATE;
            left_next    = 4'd6;
            acc_next     = '0;
            acc_cnt_next = '0;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_ERR_STATE: begin
        // first byte is the marker, the next five are the state characters
        if (left < 4'd6 && acc_cnt < 4'd5) begin
          state_chars_next = state_take;
          acc_cnt_next     = acc_cnt + 4'd1;
        end
        left_next = left_dec;
        if (left_dec == 4'd0) begin
          phase_next = PH_SKIP;
        end
      end
      PH_FE: begin
        if (byte_index >= 24'd1 && byte_index <= 24'd4) begin
          early_bytes_next = early_bytes | ({24'd0, payload_byte} << {fe_lane, 3'b000});
        end
      end
      default: begin
      end
    endcase

    if (lz_done) begin
      unique case (lz_fld)
        FLD_ROWS: begin
          rows_next  = lz_val;
          phase_next = PH_ID_PFX;
        end
        FLD_ID: begin
          insert_id_next = lz_val;
          if (cap_p41 || cap_trans) begin
            phase_next   = PH_STATUS;
            left_next    = 4'd2;
            acc_next     = '0;
            acc_cnt_next = '0;
          end else begin
            info_len_next = '0;
            phase_next    = info_phase;
          end
        end
        FLD_INFO: begin
          info_len_next = (|lz_val[63:24]) ? sqlrp_pkg::MAX24 : lz_val[23:0];
          phase_next    = PH_SKIP;
        end
        default: begin
        end
      endcase
    end

    // bad length prefix, or packet ended inside a required field
    bad_res = bad_flag_next || (phase_next inside {PH_ROWS_PFX, PH_ROWS_VAL, PH_ID_PFX,
              PH_ID_VAL, PH_INFO_VAL, PH_STATUS, PH_WARN, PH_ERR_CODE, PH_ERR_STATE});
    eof_short = (byte_index_next < sqlrp_pkg::EOF_MIN_P41);

    res_data             = '0;
    res_data.packet_kind = sqlrp_pkg::KIND_OTHER;
    if (header_value_next == sqlrp_pkg::HDR_OK) begin
      res_data.packet_kind   = sqlrp_pkg::KIND_OK;
      res_data.row_count     = rows_next;
      res_data.new_row_id    = insert_id_next;
      res_data.server_status = status_r_next;
      res_data.warning_count = warnings_r_next;
      res_data.info_length   = info_len_next;
      res_data.malformed     = bad_res;
    end else if (header_value_next == sqlrp_pkg::HDR_ERR) begin
      res_data.packet_kind = sqlrp_pkg::KIND_ERR;
      res_data.err_number  = err_code_next;
      res_data.state_text  = state_chars_next;
      res_data.malformed   = bad_res;
    end else if (header_value_next == sqlrp_pkg::HDR_EOF &&
                 byte_index_next < sqlrp_pkg::EOF_LIMIT) begin
      res_data.packet_kind = sqlrp_pkg::KIND_EOF;
      res_data.malformed   = bad_res;
      if (cap_p41) begin
        if (eof_short) begin
          res_data.malformed = 1'b1;
        end else begin
          res_data.warning_count = early_bytes_next[15:0];
          res_data.server_status = early_bytes_next[31:16];
        end
      end
    end

    res_valid = accept && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      caps <= '0;
    end else if (cfg_we) begin
      caps <= cfg_wdata;
    end
  end

  // the last byte of a packet returns the parser to its idle state
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_index   <= '0;
      header_value <= '0;
      phase        <= PH_HDR;
      left         <= '0;
      acc          <= '0;
      acc_cnt      <= '0;
      rows         <= '0;
      insert_id    <= '0;
      early_bytes  <= '0;
      status_r     <= '0;
      warnings_r   <= '0;
      err_code     <= '0;
      state_chars  <= '0;
      info_len     <= '0;
      bad_flag     <= 1'b0;
    end else if (accept) begin
      byte_index   <= byte_index_next;
      header_value <= header_value_next;
      phase        <= phase_next;
      left         <= left_next;
      acc          <= acc_next;
      acc_cnt      <= acc_cnt_next;
      rows         <= rows_next;
      insert_id    <= insert_id_next;
      early_bytes  <= early_bytes_next;
      status_r     <= status_r_next;
      warnings_r   <= warnings_r_next;
      err_code     <= err_code_next;
      state_chars  <= state_chars_next;
      info_len     <= info_len_next;
      bad_flag     <= bad_flag_next;
    end
  end

endmodule

// File: src/sqlrp_out_buf.sv
// ----------------------------------------------------------------------------
// sqlrp_out_buf
// Output register plus skid entry between the parser and the result channel.
// ----------------------------------------------------------------------------
module sqlrp_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sqlrp_pkg::result_t  push_data,
  output logic                push_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output sqlrp_pkg::result_t  out_data
);

  logic               skid_valid;
  sqlrp_pkg::result_t skid_data;
  logic               pop;

  assign push_ready = !skid_valid;
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      // fills an empty output; stalled output keeps its entry, skid takes it
      if (!out_valid) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

// File: src/sql_response_packet_parser_top.sv
// ----------------------------------------------------------------------------
// sql_response_packet_parser_top
// Parser for OK, ERR and EOF server response packets, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   pkt carries the packet payload, header byte first, one byte per transfer;
//   last_byte marks the final byte. res carries one summary per packet.
//   cfg_we/cfg_wdata write the server capability word; write it only while
//   no packet is in flight.
// Timing:
//   one byte per cycle sustained while pkt.ready is high. Each byte updates
//   the parse registers in the cycle it is taken; a packet's summary is
//   registered into the output register, or the skid if the output stalls.
//   Results drain through a two-entry buffer (output register and skid), so
//   pkt.ready drops only when both entries hold results the receiver has not
//   taken; bytes keep flowing while just one result waits.
// Reset:
//   rst clears the capability word, the parse state and both buffer entries.
// ----------------------------------------------------------------------------
module sql_response_packet_parser_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  sqlrp_byte_if.sink        pkt,
  sqlrp_result_if.source    res
);

  logic               accept;
  logic               core_valid;
  sqlrp_pkg::result_t core_data;
  logic               buf_ready;
  sqlrp_pkg::result_t out_data;

  assign pkt.ready = buf_ready;
  assign accept    = pkt.valid && buf_ready;

  sqlrp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .payload_byte (pkt.payload_byte),
    .last_byte    (pkt.last_byte),
    .res_valid    (core_valid),
    .res_data     (core_data)
  );

  sqlrp_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (core_valid),
    .push_data  (core_data),
    .push_ready (buf_ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_data   (out_data)
  );

  assign res.packet_kind   = out_data.packet_kind;
  assign res.row_count     = out_data.row_count;
  assign res.new_row_id    = out_data.new_row_id;
  assign res.server_status = out_data.server_status;
  assign res.warning_count = out_data.warning_count;
  assign res.err_number    = out_data.err_number;
  assign res.state_text    = out_data.state_text;
  assign res.info_length   = out_data.info_length;
  assign res.malformed     = out_data.malformed;

endmodule

// File: src/sqlrp_checker.sv
// ----------------------------------------------------------------------------
// sqlrp_checker
// Port-level checks on the result channel of the response parser.
// ----------------------------------------------------------------------------
`include "sql_response_packet_parser_top_defines.svh"

module sqlrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  packet_kind,
  input logic [63:0] row_count,
  input logic [63:0] new_row_id,
  input logic [15:0] server_status,
  input logic [15:0] warning_count,
  input logic [15:0] err_number,
  input logic [39:0] state_text,
  input logic [23:0] info_length,
  input logic        malformed
);

  logic         stalled;
  logic         is_other;
  logic         is_err;
  logic         other_clean;
  logic         err_clean;
  logic [242:0] res_word;

  assign stalled     = res_valid && !res_ready;
  assign is_other    = res_valid && packet_kind == sqlrp_pkg::KIND_OTHER;
  assign is_err      = res_valid && packet_kind == sqlrp_pkg::KIND_ERR;
  assign res_word    = {packet_kind, row_count, new_row_id, server_status, warning_count,
                        err_number, state_text, info_length, malformed};
  assign other_clean = row_count == '0 && new_row_id == '0 && server_status == '0 &&
                       warning_count == '0 && err_number == '0 && state_text == '0 &&
                       info_length == '0 && !malformed;
  assign err_clean   = row_count == '0 && new_row_id == '0 && server_status == '0 &&
                       warning_count == '0 && info_length == '0;

  `SQLRP_ASSERT_NEXT(a_valid_held, stalled, res_valid, "result dropped while stalled")
  `SQLRP_ASSERT_NEXT(a_data_held, stalled, $stable(res_word), "result changed while stalled")
  `SQLRP_ASSERT_NOW(a_other_zero, is_other, other_clean, "other packet with fields set")
  `SQLRP_ASSERT_NOW(a_err_layout, is_err, err_clean, "error packet with OK fields set")
  `SQLRP_ASSERT_RST(a_reset_idle, !res_valid, "result valid after reset")

endmodule

bind sql_response_packet_parser_top sqlrp_checker u_sqlrp_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .packet_kind   (res.packet_kind),
  .row_count     (res.row_count),
  .new_row_id    (res.new_row_id),
  .server_status (res.server_status),
  .warning_count (res.warning_count),
  .err_number    (res.err_number),
  .state_text    (res.state_text),
  .info_length   (res.info_length),
  .malformed     (res.malformed)
);
